>>> rtl/lesq_pkg.sv
// ----------------------------------------------------------------------------
// lesq_pkg
// Shared widths, register indexes and reset values for the empty square scan.
// ----------------------------------------------------------------------------
package lesq_pkg;

  // field widths
  localparam int CHAR_W = 8;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 2'd2;

  // reset values
  localparam logic [CHAR_W-1:0] OBSTACLE_RST = 8'd111;
  localparam logic [SIZE_W-1:0] COUNT_RST    = 11'd1;

  // largest score and largest map side
  localparam int SIZE_CAP = 1024;

  // default map limits
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

endpackage

>>> rtl/lesq_ram.sv
// ----------------------------------------------------------------------------
// lesq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lesq_ram #(
  parameter int WIDTH  = 11,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/largest_empty_square_scan.sv
// ----------------------------------------------------------------------------
// largest_empty_square_scan: one cell per cycle while the output is not stalled
// Score stage register, then output register; one line buffer read at transfer
// and one write as the score stage advances sustain it. Sync reset clears counters,
// best square, scores, config and valid flags, not data registers or line buffer.
// ----------------------------------------------------------------------------
module largest_empty_square_scan #(
  parameter int MAX_COLS = lesq_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lesq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lesq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // cell stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lesq_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] cell_char
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [10:0] cell_size, [21:11] best_size, [31:22] best_top_row,
  // [41:32] best_left_col, [47:42] zero
  output logic [lesq_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast   // map_done
);

  import lesq_pkg::*;

  localparam int EFF_COLS = (MAX_COLS < SIZE_CAP) ? MAX_COLS : SIZE_CAP;
  localparam int EFF_ROWS = (MAX_ROWS < SIZE_CAP) ? MAX_ROWS : SIZE_CAP;
  localparam int ADDR_W   = (EFF_COLS > 1) ? $clog2(EFF_COLS) : 1;
  localparam logic [SIZE_W-1:0] COL_CAP = SIZE_W'(EFF_COLS);
  localparam logic [SIZE_W-1:0] ROW_CAP = SIZE_W'(EFF_ROWS);
  localparam logic [SIZE_W:0]   SCORE_CAP = (SIZE_W+1)'(SIZE_CAP);

  // configuration registers
  logic [CHAR_W-1:0] obstacle_r;
  logic [SIZE_W-1:0] rows_cfg_r;
  logic [SIZE_W-1:0] cols_cfg_r;

  // scan position
  logic [POS_W-1:0] cur_row_r, cur_row_nxt;
  logic [POS_W-1:0] cur_col_r, cur_col_nxt;

  // score stage
  logic              s1_valid_r;
  logic              s1_obst_r;
  logic [POS_W-1:0]  s1_row_r;
  logic [POS_W-1:0]  s1_col_r;
  logic              s1_last_col_r;
  logic              s1_done_r;
  logic              s1_fwd_r;
  logic [SIZE_W-1:0] fwd_data_r;

  // running scores and best square
  logic [SIZE_W-1:0] left_r, left_nxt;
  logic [SIZE_W-1:0] diag_r, diag_nxt;
  logic [SIZE_W-1:0] peak_size_r, peak_size_nxt;
  logic [POS_W-1:0]  peak_row_r, peak_row_nxt;
  logic [POS_W-1:0]  peak_col_r, peak_col_nxt;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic in_acc;
  logic s1_adv;

  logic [SIZE_W-1:0] rows_lim;
  logic [SIZE_W-1:0] cols_lim;
  logic [SIZE_W-1:0] row_cl;
  logic [SIZE_W-1:0] col_cl;
  logic              last_row;
  logic              last_col;
  logic              done;

  logic [SIZE_W-1:0] ram_rdata;
  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] min3;
  logic [SIZE_W:0]   sum;
  logic [SIZE_W-1:0] score;
  logic [SIZE_W-1:0] row_p1;
  logic [SIZE_W-1:0] col_p1;

  assign cfg_ready = 1'b1;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r <= OBSTACLE_RST;
      rows_cfg_r <= COUNT_RST;
      cols_cfg_r <= COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OBSTACLE: obstacle_r <= cfg_data[CHAR_W-1:0];
        REG_ROWS:     rows_cfg_r <= cfg_data;
        REG_COLS:     cols_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // effective map size and clamped position
  always_comb begin
    rows_lim = rows_cfg_r;
    if (rows_lim == '0)     rows_lim = SIZE_W'(1);
    if (rows_lim > ROW_CAP) rows_lim = ROW_CAP;
    cols_lim = cols_cfg_r;
    if (cols_lim == '0)     cols_lim = SIZE_W'(1);
    if (cols_lim > COL_CAP) cols_lim = COL_CAP;

    row_cl = {1'b0, cur_row_r};
    if (row_cl >= rows_lim) row_cl = rows_lim - SIZE_W'(1);
    col_cl = {1'b0, cur_col_r};
    if (col_cl >= cols_lim) col_cl = cols_lim - SIZE_W'(1);

    last_row = ({1'b0, row_cl} + (SIZE_W+1)'(1)) >= {1'b0, rows_lim};
    last_col = ({1'b0, col_cl} + (SIZE_W+1)'(1)) >= {1'b0, cols_lim};
    done     = last_row && last_col;
  end

  // next position
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (in_acc) begin
      if (done) begin
        cur_row_nxt = '0;
        cur_col_nxt = '0;
      end else if (last_col) begin
        cur_row_nxt = row_cl[POS_W-1:0] + POS_W'(1);
        cur_col_nxt = '0;
      end else begin
        cur_row_nxt = row_cl[POS_W-1:0];
        cur_col_nxt = col_cl[POS_W-1:0] + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

  // line buffer of the previous row's scores
  lesq_ram #(
    .WIDTH  (SIZE_W),
    .DEPTH  (EFF_COLS),
    .ADDR_W (ADDR_W)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r[ADDR_W-1:0]),
    .wdata (score),
    .re    (in_acc),
    .raddr (col_cl[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // score stage register, forward when the write in flight hits the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_obst_r     <= (in_tdata[CHAR_W-1:0] == obstacle_r);
      s1_row_r      <= row_cl[POS_W-1:0];
      s1_col_r      <= col_cl[POS_W-1:0];
      s1_last_col_r <= last_col;
      s1_done_r     <= done;
      s1_fwd_r      <= s1_adv && (s1_col_r == col_cl[POS_W-1:0]);
      fwd_data_r    <= score;
    end
  end

  // cell score
  always_comb begin
    up   = s1_fwd_r ? fwd_data_r : ram_rdata;
    min3 = up;
    if (left_r < min3) min3 = left_r;
    if (diag_r < min3) min3 = diag_r;
    sum = {1'b0, min3} + (SIZE_W+1)'(1);
    if (sum > SCORE_CAP) sum = SCORE_CAP;

    if (s1_obst_r) begin
      score = '0;
    end else if (s1_row_r == '0 || s1_col_r == '0) begin
      score = SIZE_W'(1);
    end else begin
      score = sum[SIZE_W-1:0];
    end
  end

  // best square, only a strictly larger one replaces it; also next left and diag scores
  always_comb begin
    row_p1        = {1'b0, s1_row_r} + SIZE_W'(1);
    col_p1        = {1'b0, s1_col_r} + SIZE_W'(1);
    peak_size_nxt = peak_size_r;
    peak_row_nxt  = peak_row_r;
    peak_col_nxt  = peak_col_r;
    if (score > peak_size_r) begin
      peak_size_nxt = score;
      peak_row_nxt  = (score > row_p1) ? '0 : POS_W'(row_p1 - score);
      peak_col_nxt  = (score > col_p1) ? '0 : POS_W'(col_p1 - score);
    end
    left_nxt = score;
    diag_nxt = up;
    if (s1_last_col_r) begin
      left_nxt = '0;
      diag_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      peak_size_r <= '0;
      peak_row_r  <= '0;
      peak_col_r  <= '0;
    end else if (s1_adv) begin
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      if (s1_done_r) begin
        peak_size_r <= '0;
        peak_row_r  <= '0;
        peak_col_r  <= '0;
      end else begin
        peak_size_r <= peak_size_nxt;
        peak_row_r  <= peak_row_nxt;
        peak_col_r  <= peak_col_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {(OUT_DATA_W - 2*SIZE_W - 2*POS_W)'(0),
                     peak_col_nxt, peak_row_nxt, peak_size_nxt, score};
      out_last_r <= s1_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
